FILE: src/xmodem_crc_receiver_assert.svh
// Assertion macros used by the receiver's output module.
`ifndef XMODEM_CRC_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_ASSERT_SVH
`ifndef SYNTH
`define XMC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define XMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XMC_ASSERT(label, cond, msg)
`define XMC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: src/xmc_pkg.sv
// Types, constants and the CRC step shared by the XMODEM receiver.
`timescale 1ns / 1ps
package xmc_pkg;

    localparam int LONG_BLOCK_BYTES  = 1024;
    localparam int SHORT_BLOCK_BYTES = 128;
    localparam int INDEX_W           = $clog2(LONG_BLOCK_BYTES) + 1;

    localparam logic [7:0]  CH_SOH = 8'h01;
    localparam logic [7:0]  CH_STX = 8'h02;
    localparam logic [7:0]  CH_EOT = 8'h04;
    localparam logic [7:0]  CH_ACK = 8'h06;
    localparam logic [7:0]  CH_NAK = 8'h15;
    localparam logic [7:0]  CH_CAN = 8'h18;
    localparam logic [7:0]  CH_BS  = 8'h08;
    localparam logic [7:0]  CH_C   = 8'h43;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [3:0] FAIL_CAN_END = 4'd5;
    localparam logic [3:0] FAIL_LAST    = 4'd10;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_QUIET   = 2'd1;
    localparam logic [1:0] CFG_ERRLIM  = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [7:0]  QUIET_RESET   = 8'd1;
    localparam logic [3:0]  ERRLIM_RESET  = 4'd5;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        K_SEND    = 3'd0,
        K_TENT    = 3'd1,
        K_ACCEPT  = 3'd2,
        K_DISCARD = 3'd3,
        K_DONE    = 3'd4,
        K_FAIL    = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_FLUSH  = 4'd1,
        PH_HEAD   = 4'd2,
        PH_BLKNO  = 4'd3,
        PH_BLKCMP = 4'd4,
        PH_DATA   = 4'd5,
        PH_CHK1   = 4'd6,
        PH_CHK2   = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        BURST_NONE   = 2'd0,
        BURST_SINGLE = 2'd1,
        BURST_PAIR   = 2'd2,
        BURST_FAIL   = 2'd3
    } shape_t;

    typedef struct packed {
        shape_t      shape;
        kind_t       kind0;
        logic [7:0]  value0;
        kind_t       kind1;
        logic [7:0]  value1;
        logic [31:0] length;
    } burst_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int j = 0; j < 8; j++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: src/xmc_in_if.sv
// Request channel carrying one operation and received byte.
`timescale 1ns / 1ps
interface xmc_in_if;
    logic             valid;
    logic             ready;
    xmc_pkg::op_t     operation;
    logic [7:0]       rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

FILE: src/xmc_out_if.sv
// Result channel carrying one result item of the receiver.
`timescale 1ns / 1ps
interface xmc_out_if;
    logic             valid;
    logic             ready;
    xmc_pkg::kind_t   kind;
    logic [7:0]       value;
    logic [31:0]      total_length;
    logic             last;

    modport source (output valid, output kind, output value, output total_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input total_length,
                    input last, output ready);
endinterface

FILE: src/xmodem_crc_receiver.sv
// Top level of the XMODEM / XMODEM-1K receiver with CRC-16 or checksum.
//
// Requests enter on in_ch (operation: start, received byte or timer tick, plus
// rx_byte); results leave on out_ch (kind, value, total_length, last). Both
// are valid/ready channels; a request or result moves when valid and ready
// are high at a rising clock edge. Configuration is written on cfg_we with
// cfg_index 0 timeout_ticks, 1 quiet_ticks, 2 error_limit; the user writes
// it only while idle, which the block does not enforce. Each request runs
// through the protocol step in the cycle it is accepted; its first result
// is on out_ch the next cycle, and last marks its final one. A request makes
// zero, one, two or eleven results (the give-up burst of five CAN, five BS
// and a failed verdict). The output sequencer counts through a burst and
// takes the next request with its final result; requests with at most one
// result flow at one per cycle while out_ch is ready. When out_ch stalls the
// pending result holds and in_ch takes no request. Reset clears the protocol
// state to idle, loads the default registers and empties the result register.
`timescale 1ns / 1ps
module xmodem_crc_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    xmc_in_if.sink      in_ch,
    xmc_out_if.source   out_ch
);

    xmc_pkg::burst_t burst;
    logic            take;

    assign in_ch.ready = take;

    xmc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (in_ch.valid && take),
        .operation (in_ch.operation),
        .rx_byte   (in_ch.rx_byte),
        .burst     (burst)
    );

    xmc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (take),
        .burst    (burst),
        .out_ch   (out_ch)
    );

endmodule

FILE: src/xmc_core.sv
// Protocol state, configuration registers and the per-request step logic.
`timescale 1ns / 1ps
module xmc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 step_en,
    input  xmc_pkg::op_t         operation,
    input  logic [7:0]           rx_byte,
    output xmc_pkg::burst_t      burst
);

    logic [15:0] timeout_reg;
    logic [7:0]  quiet_reg;
    logic [3:0]  errlim_reg;

    xmc_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                  want_block_reg, want_block_next;
    logic [3:0]                  error_count_reg, error_count_next;
    logic                        crc_mode_reg, crc_mode_next;
    logic                        nak_is_c_reg, nak_is_c_next;
    logic                        long_block_reg, long_block_next;
    logic [xmc_pkg::INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]                  got_block_no_reg, got_block_no_next;
    logic [15:0]                 crc_acc_reg, crc_acc_next;
    logic [7:0]                  sum_acc_reg, sum_acc_next;
    logic [7:0]                  check_high_reg, check_high_next;
    logic [15:0]                 idle_count_reg, idle_count_next;
    logic [31:0]                 length_total_reg, length_total_next;

    logic [15:0]                 t_eff;
    logic [7:0]                  q_eff;
    logic [3:0]                  lim_eff;
    logic [xmc_pkg::INDEX_W-1:0] blk_len;
    logic [15:0]                 idle_sat;

    assign t_eff   = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign q_eff   = (quiet_reg == 8'd0) ? 8'd1 : quiet_reg;
    assign lim_eff = (errlim_reg == 4'd0) ? 4'd1 : errlim_reg;
    assign blk_len = long_block_reg ? xmc_pkg::INDEX_W'(xmc_pkg::LONG_BLOCK_BYTES)
                                    : xmc_pkg::INDEX_W'(xmc_pkg::SHORT_BLOCK_BYTES);
    assign idle_sat = (idle_count_reg != 16'hFFFF) ? idle_count_reg + 16'd1 : idle_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= xmc_pkg::TIMEOUT_RESET;
            quiet_reg   <= xmc_pkg::QUIET_RESET;
            errlim_reg  <= xmc_pkg::ERRLIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xmc_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                xmc_pkg::CFG_QUIET:   quiet_reg   <= cfg_data[7:0];
                xmc_pkg::CFG_ERRLIM:  errlim_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= xmc_pkg::PH_IDLE;
            want_block_reg   <= 8'd1;
            error_count_reg  <= 4'd0;
            crc_mode_reg     <= 1'b1;
            nak_is_c_reg     <= 1'b1;
            long_block_reg   <= 1'b0;
            byte_index_reg   <= '0;
            got_block_no_reg <= 8'd0;
            crc_acc_reg      <= 16'd0;
            sum_acc_reg      <= 8'd0;
            check_high_reg   <= 8'd0;
            idle_count_reg   <= 16'd0;
            length_total_reg <= 32'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            want_block_reg   <= want_block_next;
            error_count_reg  <= error_count_next;
            crc_mode_reg     <= crc_mode_next;
            nak_is_c_reg     <= nak_is_c_next;
            long_block_reg   <= long_block_next;
            byte_index_reg   <= byte_index_next;
            got_block_no_reg <= got_block_no_next;
            crc_acc_reg      <= crc_acc_next;
            sum_acc_reg      <= sum_acc_next;
            check_high_reg   <= check_high_next;
            idle_count_reg   <= idle_count_next;
            length_total_reg <= length_total_next;
        end
    end

    always_comb
    begin
        logic                        err;
        logic                        err_blk;
        logic                        finish;
        logic                        fin_ok;
        logic                        nonfatal;
        logic                        fatal;
        logic [3:0]                  ec1;
        logic [xmc_pkg::INDEX_W-1:0] idx_inc;

        phase_next        = phase_reg;
        want_block_next   = want_block_reg;
        error_count_next  = error_count_reg;
        crc_mode_next     = crc_mode_reg;
        nak_is_c_next     = nak_is_c_reg;
        long_block_next   = long_block_reg;
        byte_index_next   = byte_index_reg;
        got_block_no_next = got_block_no_reg;
        crc_acc_next      = crc_acc_reg;
        sum_acc_next      = sum_acc_reg;
        check_high_next   = check_high_reg;
        idle_count_next   = idle_count_reg;
        length_total_next = length_total_reg;

        burst        = '0;
        burst.shape  = xmc_pkg::BURST_NONE;
        burst.kind0  = xmc_pkg::K_SEND;
        burst.kind1  = xmc_pkg::K_SEND;
        err      = 1'b0;
        err_blk  = 1'b0;
        finish   = 1'b0;
        fin_ok   = 1'b0;
        nonfatal = 1'b0;
        fatal    = 1'b0;
        ec1      = error_count_reg + 4'd1;
        idx_inc  = byte_index_reg + 1'b1;

        if (step_en)
        begin
            case (operation)
                xmc_pkg::OP_START:
                begin
                    want_block_next   = 8'd1;
                    error_count_next  = 4'd0;
                    crc_mode_next     = 1'b1;
                    nak_is_c_next     = 1'b1;
                    long_block_next   = 1'b0;
                    byte_index_next   = '0;
                    got_block_no_next = 8'd0;
                    crc_acc_next      = 16'd0;
                    sum_acc_next      = 8'd0;
                    check_high_next   = 8'd0;
                    length_total_next = 32'd0;
                    phase_next        = xmc_pkg::PH_FLUSH;
                    idle_count_next   = 16'd0;
                end
                xmc_pkg::OP_BYTE:
                begin
                    if (phase_reg != xmc_pkg::PH_IDLE)
                    begin
                        idle_count_next = 16'd0;
                        case (phase_reg)
                            xmc_pkg::PH_HEAD:
                            begin
                                nak_is_c_next = 1'b0;
                                if (rx_byte == xmc_pkg::CH_SOH || rx_byte == xmc_pkg::CH_STX)
                                begin
                                    long_block_next = (rx_byte == xmc_pkg::CH_STX);
                                    phase_next      = xmc_pkg::PH_BLKNO;
                                end
                                else if (rx_byte == xmc_pkg::CH_EOT)
                                begin
                                    burst.shape  = xmc_pkg::BURST_PAIR;
                                    burst.kind0  = xmc_pkg::K_SEND;
                                    burst.value0 = xmc_pkg::CH_ACK;
                                    burst.kind1  = xmc_pkg::K_DONE;
                                    phase_next   = xmc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    err = 1'b1;
                                end
                            end
                            xmc_pkg::PH_BLKNO:
                            begin
                                got_block_no_next = rx_byte;
                                phase_next        = xmc_pkg::PH_BLKCMP;
                            end
                            xmc_pkg::PH_BLKCMP:
                            begin
                                if ((got_block_no_reg ^ rx_byte) != 8'hFF)
                                begin
                                    err     = 1'b1;
                                    err_blk = 1'b1;
                                end
                                else
                                begin
                                    byte_index_next = '0;
                                    crc_acc_next    = 16'd0;
                                    sum_acc_next    = 8'd0;
                                    phase_next      = xmc_pkg::PH_DATA;
                                end
                            end
                            xmc_pkg::PH_DATA:
                            begin
                                burst.shape     = xmc_pkg::BURST_SINGLE;
                                burst.kind0     = xmc_pkg::K_TENT;
                                burst.value0    = rx_byte;
                                crc_acc_next    = xmc_pkg::crc16_byte(crc_acc_reg, rx_byte);
                                sum_acc_next    = sum_acc_reg + rx_byte;
                                byte_index_next = idx_inc;
                                if (idx_inc >= blk_len)
                                begin
                                    phase_next = xmc_pkg::PH_CHK1;
                                end
                            end
                            xmc_pkg::PH_CHK1:
                            begin
                                if (crc_mode_reg)
                                begin
                                    check_high_next = rx_byte;
                                    phase_next      = xmc_pkg::PH_CHK2;
                                end
                                else
                                begin
                                    finish = 1'b1;
                                    fin_ok = (rx_byte == sum_acc_reg);
                                end
                            end
                            xmc_pkg::PH_CHK2:
                            begin
                                finish = 1'b1;
                                fin_ok = (check_high_reg == crc_acc_reg[15:8])
                                         && (rx_byte == crc_acc_reg[7:0]);
                            end
                            default: ;
                        endcase
                    end
                end
                xmc_pkg::OP_TICK:
                begin
                    if (phase_reg != xmc_pkg::PH_IDLE)
                    begin
                        idle_count_next = idle_sat;
                        if (phase_reg == xmc_pkg::PH_FLUSH)
                        begin
                            if (idle_sat >= {8'd0, q_eff})
                            begin
                                burst.shape     = xmc_pkg::BURST_SINGLE;
                                burst.kind0     = xmc_pkg::K_SEND;
                                burst.value0    = nak_is_c_reg ? xmc_pkg::CH_C : xmc_pkg::CH_NAK;
                                phase_next      = xmc_pkg::PH_HEAD;
                                idle_count_next = 16'd0;
                            end
                        end
                        else if (idle_sat >= t_eff)
                        begin
                            err     = 1'b1;
                            err_blk = (phase_reg >= xmc_pkg::PH_BLKNO);
                        end
                    end
                end
                default: ;
            endcase
        end

        // Block verdict after the last check byte; a repeat skips the check.
        if (finish)
        begin
            if (got_block_no_reg == want_block_reg - 8'd1)
            begin
                burst.shape      = xmc_pkg::BURST_PAIR;
                burst.kind0      = xmc_pkg::K_DISCARD;
                burst.kind1      = xmc_pkg::K_SEND;
                burst.value1     = xmc_pkg::CH_ACK;
                error_count_next = 4'd0;
                phase_next       = xmc_pkg::PH_HEAD;
                idle_count_next  = 16'd0;
            end
            else if (got_block_no_reg != want_block_reg || !fin_ok)
            begin
                err     = 1'b1;
                err_blk = 1'b1;
            end
            else
            begin
                want_block_next   = want_block_reg + 8'd1;
                length_total_next = length_total_reg + 32'(blk_len);
                burst.shape       = xmc_pkg::BURST_PAIR;
                burst.kind0       = xmc_pkg::K_ACCEPT;
                burst.kind1       = xmc_pkg::K_SEND;
                burst.value1      = xmc_pkg::CH_ACK;
                error_count_next  = 4'd0;
                phase_next        = xmc_pkg::PH_HEAD;
                idle_count_next   = 16'd0;
            end
        end

        // Count the error; fall back to checksum mode once, else give up.
        if (err)
        begin
            if (ec1 < lim_eff)
            begin
                error_count_next = ec1;
                nonfatal         = 1'b1;
            end
            else if (nak_is_c_next)
            begin
                nak_is_c_next    = 1'b0;
                crc_mode_next    = 1'b0;
                error_count_next = 4'd1;
                if (4'd1 < lim_eff)
                begin
                    nonfatal = 1'b1;
                end
                else
                begin
                    fatal = 1'b1;
                end
            end
            else
            begin
                fatal = 1'b1;
            end

            if (nonfatal)
            begin
                if (err_blk)
                begin
                    burst.shape = xmc_pkg::BURST_SINGLE;
                    burst.kind0 = xmc_pkg::K_DISCARD;
                end
                phase_next      = xmc_pkg::PH_FLUSH;
                idle_count_next = 16'd0;
            end
            if (fatal)
            begin
                burst.shape      = xmc_pkg::BURST_FAIL;
                phase_next       = xmc_pkg::PH_IDLE;
                error_count_next = 4'd0;
            end
        end

        burst.length = length_total_next;
    end

endmodule

FILE: src/xmc_out.sv
// Result register and burst sequencer that feeds the result channel.
`timescale 1ns / 1ps
`include "xmodem_crc_receiver_assert.svh"
module xmc_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  xmc_pkg::burst_t   burst,
    xmc_out_if.source         out_ch
);

    xmc_pkg::burst_t desc_reg;
    logic            valid_reg, valid_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            last_item;
    logic            out_take;
    logic            load;

    assign out_take = out_ch.valid && out_ch.ready;
    assign in_ready = !valid_reg || (out_take && last_item);
    assign load     = in_valid && in_ready && (burst.shape != xmc_pkg::BURST_NONE);

    always_comb
    begin
        out_ch.kind         = xmc_pkg::K_SEND;
        out_ch.value        = 8'd0;
        out_ch.total_length = desc_reg.length;
        last_item           = 1'b1;
        case (desc_reg.shape)
            xmc_pkg::BURST_SINGLE:
            begin
                out_ch.kind  = desc_reg.kind0;
                out_ch.value = desc_reg.value0;
            end
            xmc_pkg::BURST_PAIR:
            begin
                out_ch.kind  = cnt_reg[0] ? desc_reg.kind1 : desc_reg.kind0;
                out_ch.value = cnt_reg[0] ? desc_reg.value1 : desc_reg.value0;
                last_item    = cnt_reg[0];
            end
            xmc_pkg::BURST_FAIL:
            begin
                if (cnt_reg < xmc_pkg::FAIL_CAN_END)
                begin
                    out_ch.value = xmc_pkg::CH_CAN;
                end
                else if (cnt_reg < xmc_pkg::FAIL_LAST)
                begin
                    out_ch.value = xmc_pkg::CH_BS;
                end
                else
                begin
                    out_ch.kind = xmc_pkg::K_FAIL;
                end
                last_item = (cnt_reg == xmc_pkg::FAIL_LAST);
            end
            default: ;
        endcase
        out_ch.valid = valid_reg;
        out_ch.last  = last_item;
    end

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (out_take)
        begin
            if (last_item)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload register: load a new burst descriptor with the request.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= burst;
        end
    end

    `XMC_ASSERT(a_fail_cnt_bound, !(valid_reg && desc_reg.shape == xmc_pkg::BURST_FAIL) || cnt_reg <= xmc_pkg::FAIL_LAST, "fail burst counter past its end")
    `XMC_ASSERT(a_pair_cnt_bound, !(valid_reg && desc_reg.shape == xmc_pkg::BURST_PAIR) || cnt_reg <= 4'd1, "pair burst counter past its end")
    `XMC_ASSERT_NEXT(a_stall_holds_cnt, valid_reg && !out_ch.ready, $stable(cnt_reg), "burst advanced while stalled")
    `XMC_ASSERT_NEXT(a_drain_clears, out_take && last_item && !load, !valid_reg, "result still valid after final item")

endmodule

FILE: tb/tb_xmodem_crc_receiver.sv
// Testbench for the XMODEM receiver: protocol-aware stimulus checked against a local predictor.
`timescale 1ns / 1ps
module tb_xmodem_crc_receiver;
    import xmc_pkg::*;

    localparam logic [1:0] OP_UNKNOWN  = 2'd3;
    localparam int DRAIN_CYCLES        = 24;
    localparam int STALL_LIMIT         = 2000;
    localparam int SEGMENT_ITEMS       = 77;
    localparam int PLAN_COUNT          = 6;

    localparam logic [15:0] PLAN_TIMEOUT [PLAN_COUNT] =
        '{16'd3, 16'd65535, 16'd1, 16'd0, 16'd6, 16'd2};
    localparam logic [7:0] PLAN_QUIET [PLAN_COUNT] =
        '{8'd1, 8'd255, 8'd1, 8'd0, 8'd4, 8'd2};
    localparam logic [3:0] PLAN_ERRLIM [PLAN_COUNT] =
        '{4'd5, 4'd15, 4'd1, 4'd0, 4'd3, 4'd15};

    typedef struct {
        kind_t       kind;
        logic [7:0]  value;
        logic [31:0] total;
        logic        last;
    } reply_t;

    // Tracks the receiver's protocol state and queues the replies it owes.
    class xfer_tracker;
        logic [15:0] timeout_reg;
        logic [7:0]  quiet_reg;
        logic [3:0]  errlim_reg;
        logic [15:0] eff_timeout;
        logic [7:0]  eff_quiet;
        logic [3:0]  eff_errlim;

        phase_t      phase;
        logic [7:0]  want_block;
        logic [3:0]  error_count;
        logic        crc_mode;
        logic        nak_is_c;
        logic        long_block;
        logic [10:0] byte_index;
        logic [7:0]  got_block_no;
        logic [15:0] crc_acc;
        logic [7:0]  sum_acc;
        logic [7:0]  check_high;
        logic [15:0] idle_count;
        logic [31:0] length_total;

        reply_t      pending_replies[$];
        int          mismatches;

        function new();
            timeout_reg  = TIMEOUT_RESET;
            quiet_reg    = QUIET_RESET;
            errlim_reg   = ERRLIM_RESET;
            phase        = PH_IDLE;
            want_block   = 8'd1;
            error_count  = 4'd0;
            crc_mode     = 1'b1;
            nak_is_c     = 1'b1;
            long_block   = 1'b0;
            byte_index   = '0;
            got_block_no = '0;
            crc_acc      = '0;
            sum_acc      = '0;
            check_high   = '0;
            idle_count   = '0;
            length_total = '0;
            mismatches   = 0;
            refresh_limits();
        endfunction

        // Zero in a register acts as one.
        function void refresh_limits();
            eff_timeout = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
            eff_quiet   = (quiet_reg == 8'd0) ? 8'd1 : quiet_reg;
            eff_errlim  = (errlim_reg == 4'd0) ? 4'd1 : errlim_reg;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_TIMEOUT: timeout_reg = data;
                CFG_QUIET:   quiet_reg = data[7:0];
                CFG_ERRLIM:  errlim_reg = data[3:0];
                default: ;
            endcase
            refresh_limits();
        endfunction

        function void add_reply(kind_t k, logic [7:0] v);
            reply_t r;
            r.kind  = k;
            r.value = v;
            r.total = length_total;
            r.last  = 1'b0;
            pending_replies.push_back(r);
        endfunction

        function int block_bytes();
            return long_block ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
        endfunction

        function void go_flush();
            phase      = PH_FLUSH;
            idle_count = '0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] din);
            logic [15:0] c;
            c = acc ^ {din, 8'h00};
            for (int j = 0; j < 8; j++)
            begin
                if (c[15])
                    c = {c[14:0], 1'b0} ^ 16'h1021;
                else
                    c = {c[14:0], 1'b0};
            end
            return c;
        endfunction

        function void raise_error(bit in_block);
            error_count = error_count + 4'd1;
            if (error_count < eff_errlim)
            begin
                if (in_block)
                    add_reply(K_DISCARD, 8'h00);
                go_flush();
                return;
            end
            // Nothing heard yet: drop to checksum mode and count one error again.
            if (nak_is_c)
            begin
                nak_is_c    = 1'b0;
                crc_mode    = 1'b0;
                error_count = 4'd1;
                if (error_count < eff_errlim)
                begin
                    if (in_block)
                        add_reply(K_DISCARD, 8'h00);
                    go_flush();
                    return;
                end
            end
            repeat (5) add_reply(K_SEND, CH_CAN);
            repeat (5) add_reply(K_SEND, CH_BS);
            add_reply(K_FAIL, 8'h00);
            phase       = PH_IDLE;
            error_count = 4'd0;
        endfunction

        function void close_block(bit check_ok);
            if (got_block_no == want_block - 8'd1)
                add_reply(K_DISCARD, 8'h00);
            else if (got_block_no != want_block || !check_ok)
            begin
                raise_error(1'b1);
                return;
            end
            else
            begin
                want_block   = want_block + 8'd1;
                length_total = length_total + 32'(block_bytes());
                add_reply(K_ACCEPT, 8'h00);
            end
            error_count = 4'd0;
            add_reply(K_SEND, CH_ACK);
            phase      = PH_HEAD;
            idle_count = '0;
        endfunction

        function void take_byte(logic [7:0] din);
            idle_count = '0;
            case (phase)
                PH_HEAD:
                begin
                    nak_is_c = 1'b0;
                    if (din == CH_SOH || din == CH_STX)
                    begin
                        long_block = (din == CH_STX);
                        phase      = PH_BLKNO;
                    end
                    else if (din == CH_EOT)
                    begin
                        add_reply(K_SEND, CH_ACK);
                        add_reply(K_DONE, 8'h00);
                        phase = PH_IDLE;
                    end
                    else
                        raise_error(1'b0);
                end
                PH_BLKNO:
                begin
                    got_block_no = din;
                    phase        = PH_BLKCMP;
                end
                PH_BLKCMP:
                begin
                    if ((got_block_no ^ din) != 8'hFF)
                        raise_error(1'b1);
                    else
                    begin
                        byte_index = '0;
                        crc_acc    = '0;
                        sum_acc    = '0;
                        phase      = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    add_reply(K_TENT, din);
                    crc_acc    = crc_step(crc_acc, din);
                    sum_acc    = sum_acc + din;
                    byte_index = byte_index + 11'd1;
                    if (byte_index >= block_bytes())
                        phase = PH_CHK1;
                end
                PH_CHK1:
                begin
                    if (crc_mode)
                    begin
                        check_high = din;
                        phase      = PH_CHK2;
                    end
                    else
                        close_block(din == sum_acc);
                end
                PH_CHK2:
                    close_block(check_high == crc_acc[15:8] && din == crc_acc[7:0]);
                default: ;
            endcase
        endfunction

        function void take_tick();
            if (phase == PH_IDLE)
                return;
            if (idle_count != 16'hFFFF)
                idle_count = idle_count + 16'd1;
            if (phase == PH_FLUSH)
            begin
                if (idle_count >= {8'h00, eff_quiet})
                begin
                    add_reply(K_SEND, nak_is_c ? CH_C : CH_NAK);
                    phase      = PH_HEAD;
                    idle_count = '0;
                end
                return;
            end
            if (idle_count >= eff_timeout)
                raise_error(phase >= PH_BLKNO);
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] din);
            int before_n;
            before_n = pending_replies.size();
            case (op)
                OP_START:
                begin
                    want_block   = 8'd1;
                    error_count  = 4'd0;
                    crc_mode     = 1'b1;
                    nak_is_c     = 1'b1;
                    long_block   = 1'b0;
                    byte_index   = '0;
                    got_block_no = '0;
                    crc_acc      = '0;
                    sum_acc      = '0;
                    check_high   = '0;
                    length_total = '0;
                    go_flush();
                end
                OP_BYTE:
                    if (phase != PH_IDLE)
                        take_byte(din);
                OP_TICK:
                    take_tick();
                default: ;
            endcase
            if (pending_replies.size() > before_n)
                pending_replies[pending_replies.size() - 1].last = 1'b1;
        endfunction

        function void report(string what, reply_t exp, kind_t k, logic [7:0] v,
                             logic [31:0] tl, logic l);
            if (mismatches < 10)
                $display("%0t %s: expected kind %0d value %02h total %0d last %0b, got kind %0d value %02h total %0d last %0b",
                         $realtime, what, exp.kind, exp.value, exp.total, exp.last,
                         k, v, tl, l);
            mismatches++;
        endfunction

        function void check_result(kind_t k, logic [7:0] v, logic [31:0] tl, logic l);
            reply_t exp;
            if (pending_replies.size() == 0)
            begin
                exp = '{K_SEND, 8'h00, 32'h0, 1'b0};
                report("unexpected result", exp, k, v, tl, l);
                return;
            end
            exp = pending_replies.pop_front();
            if (k !== exp.kind || v !== exp.value || tl !== exp.total || l !== exp.last)
                report("result mismatch", exp, k, v, tl, l);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    xmc_in_if  in_ch ();
    xmc_out_if out_ch ();

    xfer_tracker tracker = new();

    bit calm;
    bit stall_head;
    int long_sent;
    int random_total;

    xmodem_crc_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    // Mostly short, a few long.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return gap_length();
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [7:0] din);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op_t'(op);
        in_ch.rx_byte   <= din;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        tracker.note_request(op, din);
    endtask

    // Drain every owed reply, let the pipeline settle, then load all three registers.
    task automatic configure(input logic [15:0] t, input logic [7:0] q, input logic [3:0] e);
        in_ch.valid <= 1'b0;
        while (tracker.pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= t;
        @(posedge clk);
        tracker.set_reg(CFG_TIMEOUT, t);
        cfg_index <= CFG_QUIET;
        cfg_data  <= {8'h00, q};
        @(posedge clk);
        tracker.set_reg(CFG_QUIET, {8'h00, q});
        cfg_index <= CFG_ERRLIM;
        cfg_data  <= {12'h000, e};
        @(posedge clk);
        tracker.set_reg(CFG_ERRLIM, {12'h000, e});
        cfg_we <= 1'b0;
    endtask

    // Choose the next request from the predicted protocol phase: mostly a
    // well-formed transfer, with errors, timeouts, aborts and noise mixed in.
    task automatic pick_request(input bit winding, output logic [1:0] op,
                                output logic [7:0] din, output bit counts);
        int r;
        r      = $urandom_range(0, 9999);
        op     = OP_BYTE;
        din    = 8'($urandom_range(0, 255));
        counts = 1'b1;
        if (!winding && tracker.phase != PH_IDLE && r < 40)
        begin
            op     = OP_UNKNOWN;
            counts = 1'b0;
            return;
        end
        case (tracker.phase)
            PH_IDLE:
            begin
                if (r < 7000)
                    op = OP_START;
                else
                begin
                    counts = 1'b0;
                    if (r < 8500)
                        op = OP_TICK;
                    else if (r >= 9500)
                        op = OP_UNKNOWN;
                end
            end
            PH_FLUSH:
            begin
                if (winding || r >= 500)
                begin
                    op     = OP_TICK;
                    counts = 1'b0;
                end
            end
            PH_HEAD:
            begin
                if (winding)
                    din = CH_EOT;
                else if (stall_head && tracker.nak_is_c)
                    op = OP_TICK;
                else if (r < 250)
                    op = OP_START;
                else if (r < 900)
                    ;
                else if (r < 1500)
                    op = OP_TICK;
                else if (r < 4000)
                    din = CH_EOT;
                else if ((long_sent == 0 && random_total > 200) || (long_sent < 2 && r < 4200))
                begin
                    din = CH_STX;
                    long_sent++;
                end
                else
                    din = CH_SOH;
            end
            PH_BLKNO:
            begin
                if (winding || r >= 800)
                    din = tracker.want_block;
                else if (r < 400)
                    din = tracker.want_block - 8'd1;
                else if (r >= 700)
                    op = OP_TICK;
            end
            PH_BLKCMP:
            begin
                if (winding || r >= 600)
                    din = ~tracker.got_block_no;
                else if (r < 500)
                    din = ~tracker.got_block_no ^ (8'd1 << $urandom_range(0, 7));
                else
                    op = OP_TICK;
            end
            PH_DATA:
            begin
                if (!winding && !tracker.long_block && r < 15)
                    op = OP_TICK;
                else if (!winding && !tracker.long_block && r < 20)
                    op = OP_START;
            end
            PH_CHK1, PH_CHK2:
            begin
                if (tracker.phase == PH_CHK2)
                    din = tracker.crc_acc[7:0];
                else
                    din = tracker.crc_mode ? tracker.crc_acc[15:8] : tracker.sum_acc;
                if (!winding && r < 800)
                    din = din ^ (8'd1 << $urandom_range(0, 7));
                else if (!winding && r < 900)
                    op = OP_TICK;
            end
            default: ;
        endcase
        // Sometimes wait out timeouts before the first header to force the fallback.
        if (op == OP_START)
            stall_head = ($urandom_range(0, 2) == 0) &&
                         (int'(tracker.eff_timeout) * int'(tracker.eff_errlim) <= 80);
    endtask

    task automatic play_random(input int budget);
        int counted;
        logic [1:0] op;
        logic [7:0] din;
        bit counts;
        counted = 0;
        while (counted < budget)
        begin
            pick_request(1'b0, op, din, counts);
            send_request(op, din);
            if (counts)
            begin
                counted++;
                random_total++;
            end
        end
        // Close the transfer cleanly so the next settings start from idle.
        while (tracker.phase != PH_IDLE)
        begin
            pick_request(1'b1, op, din, counts);
            send_request(op, din);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                tracker.check_result(out_ch.kind, out_ch.value, out_ch.total_length,
                                     out_ch.last);
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end
            else
                calm_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = gap_length() - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_TIMEOUT;
        cfg_data        <= 16'h0000;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_START;
        in_ch.rx_byte   <= 8'h00;
        stall_head   = 1'b0;
        long_sent    = 0;
        random_total = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored input while idle, timeouts into fallback, give-up,
        // bad complement, then a clean end of transfer.
        configure(16'd2, 8'd1, 4'd2);
        send_request(OP_BYTE, 8'hFF);
        send_request(OP_TICK, 8'h00);
        send_request(OP_UNKNOWN, 8'hAA);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_START, 8'h00);
        send_request(OP_UNKNOWN, 8'h55);
        repeat (7) send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, 8'h55);
        send_request(OP_START, 8'hFF);
        send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, CH_SOH);
        send_request(OP_BYTE, 8'h01);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, CH_EOT);

        for (int i = 0; i < PLAN_COUNT; i++)
        begin
            configure(PLAN_TIMEOUT[i], PLAN_QUIET[i], PLAN_ERRLIM[i]);
            play_random(SEGMENT_ITEMS);
        end

        in_ch.valid <= 1'b0;
        while (tracker.pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
